// ----- hdl/smae_pkg.sv -----
package smae_pkg;

   localparam int ELEM_WIDTH         = 32;
   localparam int INDEX_WIDTH        = 3;
   localparam int DIM_REG_WIDTH      = 4;
   localparam int OP_WIDTH           = 2;
   localparam int CSR_INDEX_WIDTH    = 3;
   localparam int CSR_DATA_WIDTH     = 4;
   localparam int MAX_DIM_DEFAULT    = 8;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROWS_A  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COLS_A  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROWS_B  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COLS_B  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OP_MODE = 3'd4;

   // operations
   localparam logic [OP_WIDTH-1:0] OP_ADD = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_SUB = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_MUL = 2'd2;

   localparam logic TARGET_B = 1'b1;

   // sequencer steps
   localparam int STEP_WIDTH = 4;
   localparam logic [STEP_WIDTH-1:0] S_LOAD  = 4'd0;
   localparam logic [STEP_WIDTH-1:0] S_CHECK = 4'd1;
   localparam logic [STEP_WIDTH-1:0] S_ELEM  = 4'd2;
   localparam logic [STEP_WIDTH-1:0] S_READ  = 4'd3;
   localparam logic [STEP_WIDTH-1:0] S_OPER  = 4'd4;
   localparam logic [STEP_WIDTH-1:0] S_MAC   = 4'd5;
   localparam logic [STEP_WIDTH-1:0] S_EMIT  = 4'd6;
   localparam logic [STEP_WIDTH-1:0] S_DONE  = 4'd7;
   localparam logic [STEP_WIDTH-1:0] S_ERR   = 4'd8;

   // jump conditions
   localparam int COND_WIDTH = 3;
   localparam logic [COND_WIDTH-1:0] COND_NONE      = 3'd0;
   localparam logic [COND_WIDTH-1:0] COND_ALWAYS    = 3'd1;
   localparam logic [COND_WIDTH-1:0] COND_NOT_FULL  = 3'd2;
   localparam logic [COND_WIDTH-1:0] COND_SHAPE_ERR = 3'd3;
   localparam logic [COND_WIDTH-1:0] COND_ADDSUB    = 3'd4;
   localparam logic [COND_WIDTH-1:0] COND_K_MORE    = 3'd5;
   localparam logic [COND_WIDTH-1:0] COND_MORE_ELEM = 3'd6;

   typedef struct packed {
      logic                  accept;
      logic                  mem_read;
      logic                  acc_clear;
      logic                  oper;
      logic                  mac;
      logic                  emit;
      logic                  emit_err;
      logic                  wait_out;
      logic                  clear_load;
      logic [COND_WIDTH-1:0] cond;
      logic [STEP_WIDTH-1:0] target;
   } ctrl_type;

   function automatic ctrl_type smae_ucode(input logic [STEP_WIDTH-1:0] step);
      ctrl_type c;
      c = '0;
      unique case (step)
         S_LOAD: begin
            c.accept = 1'b1;
            c.cond   = COND_NOT_FULL;
            c.target = S_LOAD;
         end
         S_CHECK: begin
            c.clear_load = 1'b1;
            c.cond       = COND_SHAPE_ERR;
            c.target     = S_ERR;
         end
         S_ELEM: begin
            c.acc_clear = 1'b1;
         end
         S_READ: begin
            c.mem_read = 1'b1;
         end
         S_OPER: begin
            c.oper   = 1'b1;
            c.cond   = COND_ADDSUB;
            c.target = S_EMIT;
         end
         S_MAC: begin
            c.mac    = 1'b1;
            c.cond   = COND_K_MORE;
            c.target = S_READ;
         end
         S_EMIT: begin
            c.emit     = 1'b1;
            c.wait_out = 1'b1;
            c.cond     = COND_MORE_ELEM;
            c.target   = S_ELEM;
         end
         S_DONE: begin
            c.cond   = COND_ALWAYS;
            c.target = S_LOAD;
         end
         S_ERR: begin
            c.emit_err = 1'b1;
            c.wait_out = 1'b1;
            c.cond     = COND_ALWAYS;
            c.target   = S_LOAD;
         end
         default: begin
            c.cond   = COND_ALWAYS;
            c.target = S_LOAD;
         end
      endcase
      return c;
   endfunction

endpackage

// ----- hdl/small_matrix_arith_engine_unit.sv -----
// loading: one item per cycle; the item that fills both matrices starts the run
// run: a check step, then per element clear, read, operate and emit steps (add/sub), or
// read, operate and multiply-accumulate repeated for each of cols_a terms (multiply),
// set by the single read port of each store and the shared multiply-accumulate step;
// emit waits on rsp_ready, a closing step ends the run; a shape error gives one result
// sync reset: load counters, registers (dims 1, add) and sequencer cleared; stores kept
module small_matrix_arith_engine_unit #(
   parameter int MAX_DIM    = smae_pkg::MAX_DIM_DEFAULT,
   parameter int DATA_WIDTH = smae_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_target_matrix,
   input  logic signed [smae_pkg::ELEM_WIDTH-1:0]   req_element_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [smae_pkg::ELEM_WIDTH-1:0]   rsp_result_value,
   output logic        [smae_pkg::INDEX_WIDTH-1:0]  rsp_result_row,
   output logic        [smae_pkg::INDEX_WIDTH-1:0]  rsp_result_col,
   output logic                                     rsp_shape_error,
   output logic                                     rsp_last_of_run,
   input  logic                                     csr_we,
   input  logic        [smae_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic        [smae_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import smae_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int DW    = $clog2(MAX_DIM + 1);
   localparam int WIDE  = (DATA_WIDTH > ELEM_WIDTH) ? DATA_WIDTH : ELEM_WIDTH;

   function automatic logic [DW-1:0] eff_dim(input logic [DIM_REG_WIDTH-1:0] d);
      if (d == '0) return DW'(1);
      if (32'(d) > MAX_DIM) return DW'(MAX_DIM);
      return DW'(d);
   endfunction

   // configuration
   logic [DIM_REG_WIDTH-1:0] rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;
   logic [OP_WIDTH-1:0]      op_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff  <= DIM_REG_WIDTH'(1);
         cols_a_ff  <= DIM_REG_WIDTH'(1);
         rows_b_ff  <= DIM_REG_WIDTH'(1);
         cols_b_ff  <= DIM_REG_WIDTH'(1);
         op_mode_ff <= OP_ADD;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ROWS_A:  rows_a_ff  <= csr_wdata;
            REG_COLS_A:  cols_a_ff  <= csr_wdata;
            REG_ROWS_B:  rows_b_ff  <= csr_wdata;
            REG_COLS_B:  cols_b_ff  <= csr_wdata;
            REG_OP_MODE: op_mode_ff <= csr_wdata[OP_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   logic [DW-1:0] ra, ca, rb, cb, rc;
   logic [CW-1:0] size_a, size_b;
   logic          mult_mode, shape_err;

   always_comb begin
      ra        = eff_dim(rows_a_ff);
      ca        = eff_dim(cols_a_ff);
      rb        = eff_dim(rows_b_ff);
      cb        = eff_dim(cols_b_ff);
      size_a    = CW'(ra) * CW'(ca);
      size_b    = CW'(rb) * CW'(cb);
      mult_mode = (op_mode_ff == OP_MUL);
      rc        = mult_mode ? cb : ca;
      if (mult_mode) begin
         shape_err = (ca != rb);
      end else if (op_mode_ff == OP_ADD || op_mode_ff == OP_SUB) begin
         shape_err = (ra != rb) || (ca != cb);
      end else begin
         shape_err = 1'b1;
      end
   end

   // sequencer
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   ctrl_type              ctrl;
   logic                  cond_true, hold, out_free, out_load;

   assign ctrl = smae_ucode(step_ff);

   // load counters and stores
   logic [CW-1:0] count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic          req_fire, we_a, we_b, full_next;
   logic [DATA_WIDTH-1:0] in_data;
   logic signed [WIDE-1:0] in_ext;

   assign req_ready = ctrl.accept;
   assign req_fire  = req_valid & req_ready;
   assign in_ext    = WIDE'(req_element_value);
   assign in_data   = DATA_WIDTH'(in_ext);
   assign we_a      = req_fire && (req_target_matrix != TARGET_B) && (count_a_ff < size_a);
   assign we_b      = req_fire && (req_target_matrix == TARGET_B) && (count_b_ff < size_b);

   always_comb begin
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      if (we_a) count_a_in = count_a_ff + CW'(1);
      if (we_b) count_b_in = count_b_ff + CW'(1);
      full_next = (count_a_in >= size_a) && (count_b_in >= size_b);
      if (ctrl.clear_load) begin
         count_a_in = '0;
         count_b_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
      end else begin
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
      end
   end

   logic [DATA_WIDTH-1:0] store_a_ff [DEPTH];
   logic [DATA_WIDTH-1:0] store_b_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0]         addr_a, addr_b;

   // element loop indexes
   logic [DW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic          last_elem, k_more;
   logic [CW-1:0] addr_a_w, addr_b_w;

   always_comb begin
      if (mult_mode) begin
         addr_a_w = CW'(CW'(i_ff) * CW'(ca) + CW'(k_ff));
         addr_b_w = CW'(CW'(k_ff) * CW'(cb) + CW'(j_ff));
      end else begin
         addr_a_w = CW'(CW'(i_ff) * CW'(ca) + CW'(j_ff));
         addr_b_w = addr_a_w;
      end
      addr_a = addr_a_w[AW-1:0];
      addr_b = addr_b_w[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (we_a) store_a_ff[count_a_ff[AW-1:0]] <= in_data;
      if (we_b) store_b_ff[count_b_ff[AW-1:0]] <= in_data;
      if (ctrl.mem_read) begin
         rd_a_ff <= store_a_ff[addr_a];
         rd_b_ff <= store_b_ff[addr_b];
      end
   end

   assign last_elem = (i_ff + DW'(1) == ra) && (j_ff + DW'(1) == rc);
   assign k_more    = (k_ff + DW'(1) < ca);

   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      if (ctrl.clear_load) begin
         i_in = '0;
         j_in = '0;
      end else if (ctrl.emit && out_free) begin
         if (j_ff + DW'(1) == rc) begin
            j_in = '0;
            i_in = i_ff + DW'(1);
         end else begin
            j_in = j_ff + DW'(1);
         end
      end
      if (ctrl.acc_clear) begin
         k_in = '0;
      end else if (ctrl.mac) begin
         k_in = k_ff + DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
   end

   // arithmetic
   logic [DATA_WIDTH-1:0] acc_ff, acc_in, prod_ff;
   logic [WIDE-1:0]       acc_wide;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.acc_clear) begin
         acc_in = '0;
      end else if (ctrl.oper && !mult_mode) begin
         acc_in = (op_mode_ff == OP_SUB) ? rd_a_ff - rd_b_ff : rd_a_ff + rd_b_ff;
      end else if (ctrl.mac) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctrl.oper) prod_ff <= rd_a_ff * rd_b_ff;
   end

   assign acc_wide = WIDE'(acc_ff);

   // step control
   always_comb begin
      unique case (ctrl.cond)
         COND_NONE:      cond_true = 1'b0;
         COND_ALWAYS:    cond_true = 1'b1;
         COND_NOT_FULL:  cond_true = !(req_fire && full_next);
         COND_SHAPE_ERR: cond_true = shape_err;
         COND_ADDSUB:    cond_true = !mult_mode;
         COND_K_MORE:    cond_true = k_more;
         COND_MORE_ELEM: cond_true = !last_elem;
         default:        cond_true = 1'b0;
      endcase
      hold = ctrl.wait_out && !out_free;
      priority if (hold) begin
         step_in = step_ff;
      end else if (cond_true) begin
         step_in = ctrl.target;
      end else begin
         step_in = step_ff + STEP_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) step_ff <= S_LOAD;
      else       step_ff <= step_in;
   end

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ELEM_WIDTH-1:0]  value_ff;
   logic [INDEX_WIDTH-1:0] row_ff, col_ff;
   logic                   err_ff, last_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign out_load = (ctrl.emit || ctrl.emit_err) && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (ctrl.emit_err) begin
            value_ff <= '0;
            row_ff   <= '0;
            col_ff   <= '0;
            err_ff   <= 1'b1;
            last_ff  <= 1'b1;
         end else begin
            value_ff <= acc_wide[ELEM_WIDTH-1:0];
            row_ff   <= INDEX_WIDTH'(i_ff);
            col_ff   <= INDEX_WIDTH'(j_ff);
            err_ff   <= 1'b0;
            last_ff  <= last_elem;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = value_ff;
   assign rsp_result_row   = row_ff;
   assign rsp_result_col   = col_ff;
   assign rsp_shape_error  = err_ff;
   assign rsp_last_of_run  = last_ff;

endmodule

// ----- hdl/smae_checker.sv -----
module smae_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     rsp_valid,
   input logic                                     rsp_ready,
   input logic signed [smae_pkg::ELEM_WIDTH-1:0]   rsp_result_value,
   input logic        [smae_pkg::INDEX_WIDTH-1:0]  rsp_result_row,
   input logic        [smae_pkg::INDEX_WIDTH-1:0]  rsp_result_col,
   input logic                                     rsp_shape_error,
   input logic                                     rsp_last_of_run
);
   import smae_pkg::*;

   // no result pending right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an error result stands alone
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_shape_error |-> rsp_last_of_run)
      else $error("error result not flagged last");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_shape_error |->
         rsp_result_value == '0 && rsp_result_row == '0 && rsp_result_col == '0)
      else $error("error result carries data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_result_value) && $stable(rsp_result_row)
         && $stable(rsp_result_col) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

endmodule

bind small_matrix_arith_engine_unit smae_checker u_smae_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_value (rsp_result_value),
   .rsp_result_row   (rsp_result_row),
   .rsp_result_col   (rsp_result_col),
   .rsp_shape_error  (rsp_shape_error),
   .rsp_last_of_run  (rsp_last_of_run)
);
